/* design/iialu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iialu_pkg
// Shared types for the iterative integer ALU: operation codes, controller
// states and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package iialu_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } iialu_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } iialu_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } iialu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_op;  // no iteration needed: add, subtract or trivial divide
    logic last;      // final iteration step
  } iialu_sts_t;

endpackage

/* design/iialu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iialu_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iialu_req_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic signed [DW-1:0] operand_a;
  logic signed [DW-1:0] operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface iialu_rsp_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] result_value;
  logic                 divide_error;

  modport source (output valid, result_value, divide_error, input ready);
  modport sink   (input valid, result_value, divide_error, output ready);
endinterface

/* design/iialu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iialu_ctrl
// Controller FSM: accepts a request, sequences the datapath iterations and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module iialu_ctrl
  import iialu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output iialu_cmd_t cmd_o,
  input  iialu_sts_t sts_i
);

  iialu_state_e state_q, state_d;
  logic         rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.short_op) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        // result register free, or its transfer completes this cycle
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.emit  = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

`ifndef SYNTHESIS
  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result register overwritten before transfer");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.emit}))
    else $error("datapath commands overlap");

  a_last_step_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && sts_i.last |=> state_q == ST_FIN)
    else $error("iteration did not finish after last step");

  a_load_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_RUN && !cmd_o.emit)
    else $error("load not followed by run");
`endif

endmodule

/* design/iialu_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iialu_dp
// Datapath: operand registers, shift-and-add multiplier, restoring divider
// (one bit per step) and the response payload register.
// ----------------------------------------------------------------------------
module iialu_dp
  import iialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic [1:0]                   func_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  input  iialu_cmd_t                   cmd_i,
  output iialu_sts_t                   sts_o,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         divide_error_o
);

  localparam int CntW = $clog2(DATA_WIDTH);

  iialu_func_e           func_q;
  logic [DATA_WIDTH-1:0] a_q, b_q, acc_q;
  logic [CntW-1:0]       cnt_q;
  logic                  short_q, err_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic                  res_err_q;

  iialu_func_e           func_in;
  logic                  err_in, short_in;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] result;

  assign func_in = iialu_func_e'(func_i);

  // divisor zero or negative is an error; negative dividend gives quotient 0
  always_comb begin
    err_in   = (func_in == FUNC_DIV) &&
               (operand_b_i[DATA_WIDTH-1] || (operand_b_i == '0));
    short_in = (func_in == FUNC_ADD) || (func_in == FUNC_SUB) || err_in ||
               ((func_in == FUNC_DIV) && operand_a_i[DATA_WIDTH-1]);
  end

  // remainder stays below the divisor, so its top bit is always clear
  assign rem_sh = {acc_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, b_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_in;
      a_q     <= operand_a_i;
      b_q     <= operand_b_i;
      acc_q   <= '0;
      cnt_q   <= '0;
      short_q <= short_in;
      err_q   <= err_in;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
      if (func_q == FUNC_MUL) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= {a_q[DATA_WIDTH-2:0], 1'b0};
        b_q <= {1'b0, b_q[DATA_WIDTH-1:1]};
      end else begin
        if (!diff[DATA_WIDTH]) begin
          acc_q <= diff[DATA_WIDTH-1:0];
          a_q   <= {a_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc_q <= rem_sh;
          a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    case (func_q)
      FUNC_ADD: result = a_q + b_q;
      FUNC_SUB: result = a_q - b_q;
      FUNC_MUL: result = acc_q;
      FUNC_DIV: result = short_q ? '0 : a_q;
      default:  result = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q     <= result;
      res_err_q <= err_q;
    end
  end

  assign sts_o.short_op = short_q;
  assign sts_o.last     = (cnt_q == CntW'(DATA_WIDTH - 1));

  assign result_value_o = res_q;
  assign divide_error_o = res_err_q;

endmodule

/* design/iterative_int_alu_add_sub_mul_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_int_alu_add_sub_mul_div
// Iterative integer ALU: add, subtract, shift-and-add multiply and
// restoring divide on DATA_WIDTH-bit two's-complement operands.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+-------------------------------------------
//  req_i   | in  | func, operand_a, operand_b
//  rsp_o   | out | result_value, divide_error
//
//  Add, subtract and divides needing no iteration take no iteration step;
//  multiply and divide iterate in the datapath, one bit per cycle.
//  A new request is taken once the previous result is in the response
//  register; a stalled response holds the block in its final state.
//  Asynchronous active-low reset clears the controller and response valid.
// ----------------------------------------------------------------------------
module iterative_int_alu_add_sub_mul_div
  import iialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iialu_req_if.sink   req_i,
  iialu_rsp_if.source rsp_o
);

  iialu_cmd_t cmd;
  iialu_sts_t sts;

  iialu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  iialu_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .func_i         (req_i.func),
    .operand_a_i    (req_i.operand_a),
    .operand_b_i    (req_i.operand_b),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_value_o (rsp_o.result_value),
    .divide_error_o (rsp_o.divide_error)
  );

endmodule

/* dv/iialu_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iialu_result_checker
// Watches the request and response channels of the iterative ALU, works out
// the expected sum, difference, low product word or quotient for every
// accepted request and compares each accepted response against the oldest
// outstanding one. Reports the mismatch count and the number still in flight.
// ----------------------------------------------------------------------------
module iialu_result_checker
  import iialu_pkg::*;
#(
  parameter int DW = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  iialu_req_if req_i,
  iialu_rsp_if rsp_i,
  output int   mismatch_count_o,
  output int   pending_count_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    iialu_func_e   func;
    logic [DW-1:0] operand_a;
    logic [DW-1:0] operand_b;
    logic [DW-1:0] value;
    logic          div_err;
  } alu_outcome_t;

  alu_outcome_t alu_outcomes_due[$];
  int           mismatches;

  function automatic alu_outcome_t predict_alu_outcome(iialu_func_e f, logic [DW-1:0] a,
                                                       logic [DW-1:0] b);
    alu_outcome_t r;
    r.func      = f;
    r.operand_a = a;
    r.operand_b = b;
    r.value     = '0;
    r.div_err   = 1'b0;
    case (f)
      FUNC_ADD: r.value = a + b;
      FUNC_SUB: r.value = a - b;
      FUNC_MUL: r.value = a * b;  // DW-bit context keeps the low word only
      FUNC_DIV: begin
        // non-positive divisor flags an error; dividend below divisor gives 0
        if (b == '0 || b[DW-1]) begin
          r.div_err = 1'b1;
        end else if ($signed(a) >= $signed(b)) begin
          r.value = a / b;
        end
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alu_outcome_t want;
    if (!rst_ni) begin
      alu_outcomes_due.delete();
      mismatches = 0;
    end else begin
      // response side first so a same-edge request cannot mask a stray result
      if (rsp_i.valid && rsp_i.ready) begin
        if (alu_outcomes_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected result value=%0h err=%0b", $realtime,
                     rsp_i.result_value, rsp_i.divide_error);
          mismatches++;
        end else begin
          want = alu_outcomes_due.pop_front();
          if (rsp_i.result_value !== want.value || rsp_i.divide_error !== want.div_err) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: %s a=%0h b=%0h exp value=%0h err=%0b got value=%0h err=%0b",
                       $realtime, want.func.name(), want.operand_a, want.operand_b,
                       want.value, want.div_err, rsp_i.result_value, rsp_i.divide_error);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        alu_outcomes_due.push_back(predict_alu_outcome(iialu_func_e'(req_i.func),
                                                       req_i.operand_a, req_i.operand_b));
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= alu_outcomes_due.size();
  end

endmodule

/* dv/tb_iterative_int_alu_add_sub_mul_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterative_int_alu_add_sub_mul_div
// Drives directed corner operations then random add/subtract/multiply/divide
// requests in bursts, with the response side stalling on its own pattern and
// two long hold-offs; the checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_iterative_int_alu_add_sub_mul_div;
  import iialu_pkg::*;

  localparam int            DW           = 32;
  localparam int            RANDOM_ITEMS = 1350;
  localparam int            CYCLE_LIMIT  = 1000000;
  localparam int            HOLD_CYCLES  = 300;
  localparam int            DRAIN_CYCLES = DW + 8;
  localparam logic [DW-1:0] MAX_POS      = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_NEG      = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;
  int   result_mismatches;
  int   results_pending;
  int   holds_requested;
  int   cycle_count;

  iialu_req_if #(.DW(DW)) req_if ();
  iialu_rsp_if #(.DW(DW)) rsp_if ();

  iterative_int_alu_add_sub_mul_div #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  iialu_result_checker #(
    .DW(DW)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_if),
    .rsp_i           (rsp_if),
    .mismatch_count_o(result_mismatches),
    .pending_count_o (results_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // response side: random stall modes, plus a long hold-off on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       holds_served;
    mode         = RX_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: rsp_if.ready <= 1'b1;
          RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 9) == 0);
          default:   rsp_if.ready <= ~rsp_if.ready;
        endcase
      end
    end
  end

  // called just after a rising edge; returns at the edge of the transfer
  task automatic send_alu_op(input iialu_func_e f, input logic [DW-1:0] a,
                             input logic [DW-1:0] b);
    req_if.valid     <= 1'b1;
    req_if.func      <= f;
    req_if.operand_a <= a;
    req_if.operand_b <= b;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'($urandom);
      4, 5:       return DW'($urandom_range(0, 32) - 16);
      6: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return DW'(1);
          2:       return '1;
          3:       return MAX_POS;
          default: return MIN_NEG;
        endcase
      end
      7:       return DW'($urandom_range(1, 1000));
      default: return DW'($urandom) >> $urandom_range(1, DW - 1);
    endcase
  endfunction

  initial begin
    iialu_func_e   f;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    int            burst_left;
    holds_requested  = 0;
    burst_left       = 0;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.func      <= FUNC_ADD;
    req_if.operand_a <= '0;
    req_if.operand_b <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: wrap-around, signed multiplier, divide special cases
    send_alu_op(FUNC_ADD, MAX_POS, MAX_POS);
    send_alu_op(FUNC_ADD, MIN_NEG, MIN_NEG);
    send_alu_op(FUNC_ADD, '1, DW'(1));
    send_alu_op(FUNC_SUB, MIN_NEG, DW'(1));
    send_alu_op(FUNC_SUB, '0, MIN_NEG);
    send_alu_op(FUNC_SUB, '0, '1);
    send_alu_op(FUNC_MUL, MAX_POS, MAX_POS);
    send_alu_op(FUNC_MUL, MIN_NEG, '1);
    send_alu_op(FUNC_MUL, DW'(5), DW'(-3));
    send_alu_op(FUNC_MUL, DW'(-7), DW'(-9));
    send_alu_op(FUNC_MUL, DW'(32'h1234_5678), DW'(32'h9abc_def0));
    send_alu_op(FUNC_MUL, '1, '0);
    send_alu_op(FUNC_DIV, DW'(100), '0);
    send_alu_op(FUNC_DIV, DW'(100), '1);
    send_alu_op(FUNC_DIV, MAX_POS, MIN_NEG);
    send_alu_op(FUNC_DIV, DW'(100), DW'(7));
    send_alu_op(FUNC_DIV, DW'(7), DW'(100));
    send_alu_op(FUNC_DIV, DW'(-100), DW'(7));
    send_alu_op(FUNC_DIV, MIN_NEG, DW'(1));
    send_alu_op(FUNC_DIV, MAX_POS, DW'(1));
    send_alu_op(FUNC_DIV, MAX_POS, MAX_POS);
    send_alu_op(FUNC_DIV, '0, DW'(5));
    send_alu_op(FUNC_DIV, DW'(5), DW'(5));
    send_alu_op(FUNC_DIV, MAX_POS, DW'(3));
    wait_for_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400 || i == 1100) holds_requested++;  // sender keeps offering meanwhile
      if (i == 800) wait_for_results();
      if (burst_left == 0) begin
        idle_sender($urandom_range(0, 12));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      f = iialu_func_e'($urandom_range(0, 3));
      a = pick_operand();
      b = pick_operand();
      // most divides get a non-negative dividend and a divisor of similar scale
      if (f == FUNC_DIV && $urandom_range(0, 3) != 0) begin
        a[DW-1] = 1'b0;
        b = (a >> $urandom_range(0, DW - 1)) + DW'($urandom_range(0, 3)) - DW'(1);
      end
      send_alu_op(f, a, b);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_mismatches == 0 && results_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/iialu_pkg.sv
design/iialu_if.sv
design/iialu_ctrl.sv
design/iialu_dp.sv
design/iterative_int_alu_add_sub_mul_div.sv
dv/iialu_result_checker.sv
dv/tb_iterative_int_alu_add_sub_mul_div.sv
